FILE: sv/polynomial_segment_interpolator_core_assert.svh
// Assertion macros for the interpolator RTL.
`ifndef POLYNOMIAL_SEGMENT_INTERPOLATOR_CORE_ASSERT_SVH
`define POLYNOMIAL_SEGMENT_INTERPOLATOR_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define PSI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psi assertion failed");

// Condition must hold in the cycle after the trigger.
`define PSI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psi assertion failed");

`endif

FILE: sv/psi_pkg.sv
// Types, codes and microcode table of the polynomial segment interpolator.
package psi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_N = 64 + FRAC_BITS;
	localparam int DIV_CW = $clog2(DIV_N);
	localparam int UCODE_DEPTH = 113;
	localparam int UPC_W = $clog2(UCODE_DEPTH);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [1:0] ORD_CUBIC = 2'd2;
	localparam logic [1:0] ORD_QUINTIC = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LOADED = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [2:0] OP_MULK = 3'd0;
	localparam logic [2:0] OP_LDT = 3'd1;
	localparam logic [2:0] OP_ADDT = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_DIV2 = 3'd4;
	localparam logic [2:0] OP_MULX = 3'd5;
	localparam logic [2:0] OP_ST = 3'd6;

	localparam logic [3:0] SRC_D = 4'd0;
	localparam logic [3:0] SRC_SV = 4'd1;
	localparam logic [3:0] SRC_SA = 4'd2;
	localparam logic [3:0] SRC_EV = 4'd3;
	localparam logic [3:0] SRC_EA = 4'd4;
	localparam logic [3:0] SRC_C0 = 4'd5;
	localparam logic [3:0] SRC_C1 = 4'd6;
	localparam logic [3:0] SRC_C2 = 4'd7;
	localparam logic [3:0] SRC_C3 = 4'd8;
	localparam logic [3:0] SRC_C4 = 4'd9;
	localparam logic [3:0] SRC_C5 = 4'd10;

	localparam logic [3:0] DST_C1 = 4'd0;
	localparam logic [3:0] DST_C2 = 4'd1;
	localparam logic [3:0] DST_C3 = 4'd2;
	localparam logic [3:0] DST_C4 = 4'd3;
	localparam logic [3:0] DST_C5 = 4'd4;
	localparam logic [3:0] DST_P = 4'd5;
	localparam logic [3:0] DST_V = 4'd6;
	localparam logic [3:0] DST_A = 4'd7;

	localparam logic [UPC_W-1:0] ENT_LIN = UPC_W'(0);
	localparam logic [UPC_W-1:0] ENT_CUB = UPC_W'(4);
	localparam logic [UPC_W-1:0] ENT_QUI = UPC_W'(23);
	localparam logic [UPC_W-1:0] ENT_SMP = UPC_W'(68);

	typedef struct packed {
		logic req_type;
		logic [1:0] poly_order;
		logic signed [31:0] start_pos;
		logic signed [31:0] start_vel;
		logic signed [31:0] start_acc;
		logic signed [31:0] end_pos;
		logic signed [31:0] end_vel;
		logic signed [31:0] end_acc;
		logic [31:0] seg_start_time;
		logic [31:0] seg_duration;
		logic [31:0] sample_time;
	} psi_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] out_pos;
		logic signed [31:0] out_vel;
		logic signed [31:0] out_acc;
	} psi_rsp_t;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] sel;
		logic signed [5:0] k;
		logic last;
	} psi_uinst_t;

	typedef struct packed {
		logic capture;
		logic go;
		psi_uinst_t ui;
		logic publish;
		logic [1:0] status;
	} psi_cmd_t;

	typedef struct packed {
		logic is_smp;
		logic oor;
		logic t_zero;
		logic [1:0] ord;
		logic done;
	} psi_sts_t;

	function automatic psi_uinst_t u_mk(input logic [2:0] op, input logic [3:0] sel,
			input logic signed [5:0] k, input logic last);
		psi_uinst_t u;
		u.op = op;
		u.sel = sel;
		u.k = k;
		u.last = last;
		return u;
	endfunction

	function automatic psi_uinst_t um(input logic [3:0] sel, input logic signed [5:0] k);
		return u_mk(OP_MULK, sel, k, 1'b0);
	endfunction

	function automatic psi_uinst_t uo(input logic [2:0] op);
		return u_mk(op, 4'd0, 6'sd0, 1'b0);
	endfunction

	function automatic psi_uinst_t us(input logic [3:0] dst, input logic last);
		return u_mk(OP_ST, dst, 6'sd0, last);
	endfunction

	// Programs: linear, cubic and quintic coefficient setup, then sample evaluation.
	function automatic psi_uinst_t ucode(input logic [UPC_W-1:0] pc);
		psi_uinst_t u;
		case (int'(pc))
			0: u = um(SRC_D, 6'sd1);
			1: u = uo(OP_LDT);
			2: u = uo(OP_DIV);
			3: u = us(DST_C1, 1'b1);
			4: u = um(SRC_D, 6'sd3);
			5: u = uo(OP_LDT);
			6: u = uo(OP_DIV);
			7: u = um(SRC_SV, -6'sd2);
			8: u = uo(OP_ADDT);
			9: u = um(SRC_EV, -6'sd1);
			10: u = uo(OP_ADDT);
			11: u = uo(OP_DIV);
			12: u = us(DST_C2, 1'b0);
			13: u = um(SRC_D, -6'sd2);
			14: u = uo(OP_LDT);
			15: u = uo(OP_DIV);
			16: u = um(SRC_SV, 6'sd1);
			17: u = uo(OP_ADDT);
			18: u = um(SRC_EV, 6'sd1);
			19: u = uo(OP_ADDT);
			20: u = uo(OP_DIV);
			21: u = uo(OP_DIV);
			22: u = us(DST_C3, 1'b1);
			23: u = um(SRC_D, 6'sd20);
			24: u = uo(OP_LDT);
			25: u = uo(OP_DIV);
			26: u = um(SRC_SV, -6'sd12);
			27: u = uo(OP_ADDT);
			28: u = um(SRC_EV, -6'sd8);
			29: u = uo(OP_ADDT);
			30: u = uo(OP_DIV);
			31: u = um(SRC_EA, 6'sd1);
			32: u = uo(OP_ADDT);
			33: u = um(SRC_SA, -6'sd3);
			34: u = uo(OP_ADDT);
			35: u = uo(OP_DIV2);
			36: u = us(DST_C3, 1'b0);
			37: u = um(SRC_D, -6'sd30);
			38: u = uo(OP_LDT);
			39: u = uo(OP_DIV);
			40: u = um(SRC_SV, 6'sd16);
			41: u = uo(OP_ADDT);
			42: u = um(SRC_EV, 6'sd14);
			43: u = uo(OP_ADDT);
			44: u = uo(OP_DIV);
			45: u = um(SRC_SA, 6'sd3);
			46: u = uo(OP_ADDT);
			47: u = um(SRC_EA, -6'sd2);
			48: u = uo(OP_ADDT);
			49: u = uo(OP_DIV);
			50: u = uo(OP_DIV2);
			51: u = us(DST_C4, 1'b0);
			52: u = um(SRC_D, 6'sd12);
			53: u = uo(OP_LDT);
			54: u = uo(OP_DIV);
			55: u = um(SRC_SV, -6'sd6);
			56: u = uo(OP_ADDT);
			57: u = um(SRC_EV, -6'sd6);
			58: u = uo(OP_ADDT);
			59: u = uo(OP_DIV);
			60: u = um(SRC_EA, 6'sd1);
			61: u = uo(OP_ADDT);
			62: u = um(SRC_SA, -6'sd1);
			63: u = uo(OP_ADDT);
			64: u = uo(OP_DIV);
			65: u = uo(OP_DIV);
			66: u = uo(OP_DIV2);
			67: u = us(DST_C5, 1'b1);
			68: u = um(SRC_C5, 6'sd1);
			69: u = uo(OP_LDT);
			70: u = uo(OP_MULX);
			71: u = um(SRC_C4, 6'sd1);
			72: u = uo(OP_ADDT);
			73: u = uo(OP_MULX);
			74: u = um(SRC_C3, 6'sd1);
			75: u = uo(OP_ADDT);
			76: u = uo(OP_MULX);
			77: u = um(SRC_C2, 6'sd1);
			78: u = uo(OP_ADDT);
			79: u = uo(OP_MULX);
			80: u = um(SRC_C1, 6'sd1);
			81: u = uo(OP_ADDT);
			82: u = uo(OP_MULX);
			83: u = um(SRC_C0, 6'sd1);
			84: u = uo(OP_ADDT);
			85: u = us(DST_P, 1'b0);
			86: u = um(SRC_C5, 6'sd5);
			87: u = uo(OP_LDT);
			88: u = uo(OP_MULX);
			89: u = um(SRC_C4, 6'sd4);
			90: u = uo(OP_ADDT);
			91: u = uo(OP_MULX);
			92: u = um(SRC_C3, 6'sd3);
			93: u = uo(OP_ADDT);
			94: u = uo(OP_MULX);
			95: u = um(SRC_C2, 6'sd2);
			96: u = uo(OP_ADDT);
			97: u = uo(OP_MULX);
			98: u = um(SRC_C1, 6'sd1);
			99: u = uo(OP_ADDT);
			100: u = us(DST_V, 1'b0);
			101: u = um(SRC_C5, 6'sd20);
			102: u = uo(OP_LDT);
			103: u = uo(OP_MULX);
			104: u = um(SRC_C4, 6'sd12);
			105: u = uo(OP_ADDT);
			106: u = uo(OP_MULX);
			107: u = um(SRC_C3, 6'sd6);
			108: u = uo(OP_ADDT);
			109: u = uo(OP_MULX);
			110: u = um(SRC_C2, 6'sd2);
			111: u = uo(OP_ADDT);
			112: u = us(DST_A, 1'b1);
			default: u = u_mk(OP_LDT, 4'd0, 6'sd0, 1'b1);
		endcase
		return u;
	endfunction

endpackage

FILE: sv/polynomial_segment_interpolator_core.sv
// Sample in range: 12 time products on one 32x32 multiplier.
// Out-of-range sample and zero-duration load go from decode straight to the result, with no microcode.
// Load: runs the linear, cubic or quintic setup program on the divider.
// One item at a time; req_stall stays high until the result is in the output register.
// Reset clears coefficients, held start time and duration; a stamp of zero then gives zeros.
module polynomial_segment_interpolator_core import psi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input psi_req_t req_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output psi_rsp_t rsp_data
);

	psi_cmd_t cmd;
	psi_sts_t sts;

	psi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd(cmd),
		.sts(sts)
	);

	psi_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.req_data(req_data),
		.cmd(cmd),
		.sts(sts),
		.rsp_data(rsp_data)
	);

endmodule

FILE: sv/psi_dpath.sv
// Datapath: operand registers, coefficient store, shared divider and time multiplier.
module psi_dpath import psi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input psi_req_t req_data,
	input psi_cmd_t cmd,
	output psi_sts_t sts,
	output psi_rsp_t rsp_data
);

	localparam int MAG_W = 96;

	function automatic logic [63:0] mag64(input logic [63:0] a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic [63:0] from_mag(input logic neg, input logic [MAG_W-1:0] m);
		logic [63:0] lo;
		lo = m[63:0];
		if (neg) begin
			return (|m[MAG_W-1:63]) ? 64'h8000_0000_0000_0000 : (~lo + 64'd1);
		end
		return (|m[MAG_W-1:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : lo;
	endfunction

	function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] to_wide(input logic [31:0] v);
		return {{(32 - FRAC_BITS){v[31]}}, v, {FRAC_BITS{1'b0}}};
	endfunction

	function automatic logic [31:0] to_out(input logic [63:0] a);
		logic [63:0] m;
		m = mag64(a) >> FRAC_BITS;
		if (a[63]) begin
			return (m > 64'h8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
		end
		return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	logic [2:0] op;
	logic [3:0] sel;
	logic go;

	logic [63:0] d_q, sv_q, sa_q, ev_q, ea_q;
	logic [63:0] c0_q, c1_q, c2_q, c3_q, c4_q, c5_q;
	logic [31:0] start_q, t_q, x_q;
	logic [1:0] ord_q;
	logic is_smp_q, oor_q;
	logic [63:0] acc_q, tmp_q, p_q, v_q, a_q;
	psi_rsp_t rsp_q;

	logic [DIV_N-1:0] dv_sh_q;
	logic [32:0] dv_rem_q, dv_den_q;
	logic [63:0] dv_quo_q;
	logic dv_ovf_q, dv_neg_q, dv_busy_q;
	logic [DIV_CW-1:0] dv_cnt_q;

	logic [63:0] mx_mag_q, mx_lo_q, mx_hi_q;
	logic mx_neg_q, mx_busy_q;
	logic [1:0] mx_ph_q;

	logic [63:0] src_val, kres, dv_res, mx_res;
	logic [5:0] kmag;
	logic [69:0] kprod;
	logic [33:0] rem_sh;
	logic dv_ge, dv_last, dv_ovf_n, mx_last;
	logic [32:0] rem_n;
	logic [63:0] quo_n;
	logic [31:0] mul_a;
	logic [63:0] mul_p;
	logic [95:0] mx_sum, mx_shr;
	logic [32:0] stamp_diff;
	logic [63:0] sp_w, sa_w;

	assign op = cmd.ui.op;
	assign sel = cmd.ui.sel;
	assign go = cmd.go;

	always_comb begin
		unique case (sel)
			SRC_D: src_val = d_q;
			SRC_SV: src_val = sv_q;
			SRC_SA: src_val = sa_q;
			SRC_EV: src_val = ev_q;
			SRC_EA: src_val = ea_q;
			SRC_C0: src_val = c0_q;
			SRC_C1: src_val = c1_q;
			SRC_C2: src_val = c2_q;
			SRC_C3: src_val = c3_q;
			SRC_C4: src_val = c4_q;
			SRC_C5: src_val = c5_q;
			default: src_val = '0;
		endcase
	end

	// Product with a small signed constant, saturated on its magnitude.
	assign kmag = cmd.ui.k[5] ? (~cmd.ui.k + 6'd1) : cmd.ui.k;
	assign kprod = mag64(src_val) * kmag;
	assign kres = from_mag(src_val[63] ^ cmd.ui.k[5], {{(MAG_W - 70){1'b0}}, kprod});

	// Restoring divider, one quotient bit per cycle over the dividend scaled by 2^F.
	assign rem_sh = {dv_rem_q, dv_sh_q[DIV_N-1]};
	assign dv_ge = rem_sh >= {1'b0, dv_den_q};
	assign rem_n = dv_ge ? 33'(rem_sh - {1'b0, dv_den_q}) : rem_sh[32:0];
	assign quo_n = {dv_quo_q[62:0], dv_ge};
	assign dv_ovf_n = dv_ovf_q | dv_quo_q[63];
	assign dv_last = dv_busy_q && (dv_cnt_q == DIV_CW'(DIV_N - 1));
	assign dv_res = from_mag(dv_neg_q, {{(MAG_W - 65){1'b0}}, dv_ovf_n, quo_n});

	// Time product on one 32x32 multiplier: low half, high half, then sum and scale.
	assign mul_a = (mx_ph_q == 2'd0) ? mx_mag_q[31:0] : mx_mag_q[63:32];
	assign mul_p = mul_a * x_q;
	assign mx_sum = {mx_hi_q, 32'd0} + {32'd0, mx_lo_q};
	assign mx_shr = mx_sum >> FRAC_BITS;
	assign mx_res = from_mag(mx_neg_q, mx_shr);
	assign mx_last = mx_busy_q && (mx_ph_q == 2'd2);

	assign stamp_diff = {1'b0, req_data.sample_time} - {1'b0, start_q};
	assign sp_w = to_wide(req_data.start_pos);
	assign sa_w = to_wide(req_data.start_acc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q <= '0;
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			start_q <= '0;
			t_q <= '0;
			ord_q <= '0;
			is_smp_q <= 1'b0;
			oor_q <= 1'b0;
			dv_busy_q <= 1'b0;
			dv_cnt_q <= '0;
			mx_busy_q <= 1'b0;
			mx_ph_q <= '0;
		end else begin
			if (cmd.capture) begin
				if (req_data.req_type == REQ_LOAD) begin
					is_smp_q <= 1'b0;
					ord_q <= req_data.poly_order;
					start_q <= req_data.seg_start_time;
					t_q <= req_data.seg_duration;
					c0_q <= sp_w;
					c1_q <= (req_data.poly_order == ORD_CUBIC ||
						req_data.poly_order == ORD_QUINTIC) ? to_wide(req_data.start_vel) : '0;
					c2_q <= (req_data.poly_order == ORD_QUINTIC) ? {sa_w[63], sa_w[63:1]} : '0;
					c3_q <= '0;
					c4_q <= '0;
					c5_q <= '0;
				end else begin
					is_smp_q <= 1'b1;
					oor_q <= stamp_diff[32] | (stamp_diff[31:0] > t_q);
				end
			end
			if (go && op == OP_ST) begin
				case (sel)
					DST_C1: c1_q <= acc_q;
					DST_C2: c2_q <= acc_q;
					DST_C3: c3_q <= acc_q;
					DST_C4: c4_q <= acc_q;
					DST_C5: c5_q <= acc_q;
					default: ;
				endcase
			end
			if (go && (op == OP_DIV || op == OP_DIV2)) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q <= '0;
			end else if (dv_busy_q) begin
				if (dv_last) dv_busy_q <= 1'b0;
				dv_cnt_q <= dv_cnt_q + 1'b1;
			end
			if (go && op == OP_MULX) begin
				mx_busy_q <= 1'b1;
				mx_ph_q <= '0;
			end else if (mx_busy_q) begin
				if (mx_last) mx_busy_q <= 1'b0;
				mx_ph_q <= mx_ph_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (req_data.req_type == REQ_LOAD) begin
				d_q <= to_wide(req_data.end_pos) - sp_w;
				sv_q <= to_wide(req_data.start_vel);
				sa_q <= sa_w;
				ev_q <= to_wide(req_data.end_vel);
				ea_q <= to_wide(req_data.end_acc);
			end else begin
				x_q <= stamp_diff[31:0];
			end
		end
		if (go) begin
			unique case (op)
				OP_MULK: tmp_q <= kres;
				OP_LDT: acc_q <= tmp_q;
				OP_ADDT: acc_q <= sadd(acc_q, tmp_q);
				OP_DIV, OP_DIV2: begin
					dv_sh_q <= {mag64(acc_q), {FRAC_BITS{1'b0}}};
					dv_rem_q <= '0;
					dv_quo_q <= '0;
					dv_ovf_q <= 1'b0;
					dv_neg_q <= acc_q[63];
					dv_den_q <= (op == OP_DIV2) ? {t_q, 1'b0} : {1'b0, t_q};
				end
				OP_MULX: begin
					mx_mag_q <= mag64(acc_q);
					mx_neg_q <= acc_q[63];
				end
				OP_ST: begin
					case (sel)
						DST_P: p_q <= acc_q;
						DST_V: v_q <= acc_q;
						DST_A: a_q <= acc_q;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (dv_busy_q) begin
			dv_sh_q <= dv_sh_q << 1;
			dv_rem_q <= rem_n;
			dv_quo_q <= quo_n;
			dv_ovf_q <= dv_ovf_n;
			if (dv_last) acc_q <= dv_res;
		end
		if (mx_busy_q) begin
			case (mx_ph_q)
				2'd0: mx_lo_q <= mul_p;
				2'd1: mx_hi_q <= mul_p;
				default: acc_q <= mx_res;
			endcase
		end
		if (cmd.publish) begin
			rsp_q.status <= cmd.status;
			rsp_q.out_pos <= (cmd.status == ST_OK) ? to_out(p_q) : '0;
			rsp_q.out_vel <= (cmd.status == ST_OK) ? to_out(v_q) : '0;
			rsp_q.out_acc <= (cmd.status == ST_OK) ? to_out(a_q) : '0;
		end
	end

	assign sts.is_smp = is_smp_q;
	assign sts.oor = oor_q;
	assign sts.t_zero = (t_q == 32'd0);
	assign sts.ord = ord_q;
	assign sts.done = dv_last | mx_last;
	assign rsp_data = rsp_q;

endmodule

FILE: sv/psi_ctrl.sv
// Controller: microcode sequencer, handshakes and result valid flag.
`include "polynomial_segment_interpolator_core_assert.svh"
module psi_ctrl import psi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input logic rsp_stall,
	output psi_cmd_t cmd,
	input psi_sts_t sts
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_ISSUE = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q;
	logic [UPC_W-1:0] pc_q;
	logic [1:0] code_q;
	logic rsp_valid_q;
	psi_uinst_t ui;
	logic multi;

	assign ui = ucode(pc_q);
	assign multi = (ui.op == OP_DIV) || (ui.op == OP_DIV2) || (ui.op == OP_MULX);

	always_comb begin
		cmd = '0;
		cmd.capture = (state_q == S_IDLE) && req_valid;
		cmd.go = (state_q == S_ISSUE);
		cmd.ui = ui;
		cmd.publish = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);
		cmd.status = code_q;
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			code_q <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (sts.is_smp) begin
						if (sts.oor) begin
							code_q <= ST_RANGE;
							state_q <= S_FIN;
						end else begin
							code_q <= ST_OK;
							pc_q <= ENT_SMP;
							state_q <= S_ISSUE;
						end
					end else begin
						code_q <= ST_LOADED;
						// A zero duration keeps the start values already in place.
						if (sts.t_zero) begin
							state_q <= S_FIN;
						end else begin
							case (sts.ord)
								ORD_CUBIC: pc_q <= ENT_CUB;
								ORD_QUINTIC: pc_q <= ENT_QUI;
								default: pc_q <= ENT_LIN;
							endcase
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					if (multi) state_q <= S_WAIT;
					else if (ui.last) state_q <= S_FIN;
					else pc_q <= pc_q + 1'b1;
				end
				S_WAIT: begin
					if (sts.done) begin
						pc_q <= pc_q + 1'b1;
						state_q <= S_ISSUE;
					end
				end
				S_FIN: begin
					if (cmd.publish) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PSI_ASSERT_NEXT(a_accept_decide, req_valid && !req_stall, state_q == S_DECIDE)
	`PSI_ASSERT_NOW(a_done_in_wait, sts.done, state_q == S_WAIT)
	`PSI_ASSERT_NOW(a_pc_range, state_q == S_ISSUE, pc_q < UPC_W'(UCODE_DEPTH))
	`PSI_ASSERT_NEXT(a_publish_idle, cmd.publish, (state_q == S_IDLE) && rsp_valid_q)

endmodule

FILE: tb/sv/psi_checker.sv
// Checker for the polynomial segment interpolator: watches both channels, predicts and compares.
module psi_checker import psi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input psi_req_t req_data,
	input logic rsp_valid,
	input logic rsp_stall,
	input psi_rsp_t rsp_data,
	output int fail_count,
	output int pending
);

	localparam logic signed [127:0] MAX64 = {65'b0, {63{1'b1}}};
	localparam logic signed [127:0] MIN64 = {{65{1'b1}}, 63'b0};
	localparam logic signed [127:0] ONE_Q = 128'sd1 <<< FRAC_BITS;

	longint coef [6];
	logic [31:0] seg_t0;
	logic [31:0] seg_len;
	psi_rsp_t expected_rsp [$];

	function automatic longint clamp64(input logic signed [127:0] v);
		if (v > MAX64)
			return MAX64[63:0];
		if (v < MIN64)
			return MIN64[63:0];
		return v[63:0];
	endfunction

	function automatic longint sat_add(input longint a, input longint b);
		logic signed [127:0] s;
		s = a;
		s = s + b;
		return clamp64(s);
	endfunction

	function automatic longint sat_mul(input longint a, input longint k);
		logic signed [127:0] s;
		s = a;
		s = s * k;
		return clamp64(s);
	endfunction

	// Quotient keeps the coefficient scale: a * 2^F / dv, truncated toward zero.
	function automatic longint div_q(input longint a, input logic [63:0] dv);
		logic signed [127:0] n;
		logic signed [127:0] dd;
		n = a;
		n = n <<< FRAC_BITS;
		dd = {64'b0, dv};
		return clamp64(n / dd);
	endfunction

	function automatic longint mul_time(input longint a, input logic [31:0] x);
		logic signed [127:0] n;
		n = a;
		n = n * $signed({96'b0, x});
		return clamp64(n / ONE_Q);
	endfunction

	function automatic longint widen(input logic signed [31:0] v);
		longint r;
		r = v;
		return r <<< FRAC_BITS;
	endfunction

	function automatic logic [31:0] narrow(input longint a);
		logic signed [127:0] n;
		n = a;
		n = n / ONE_Q;
		if (n > 128'sd2147483647)
			return 32'h7FFF_FFFF;
		if (n < -128'sd2147483648)
			return 32'h8000_0000;
		return n[31:0];
	endfunction

	function automatic psi_rsp_t interpolate(input psi_req_t r);
		psi_rsp_t e;
		longint sp, sv, sa, ev, ea, d, a, p, v, ac;
		logic [63:0] t, t2;
		logic [31:0] x;
		e = '0;
		if (r.req_type == REQ_LOAD) begin
			sp = widen(r.start_pos);
			sv = widen(r.start_vel);
			sa = widen(r.start_acc);
			ev = widen(r.end_vel);
			ea = widen(r.end_acc);
			d = widen(r.end_pos) - sp;
			t = {32'b0, r.seg_duration};
			t2 = t * 2;
			for (int i = 0; i < 6; i++)
				coef[i] = 0;
			seg_t0 = r.seg_start_time;
			seg_len = r.seg_duration;
			coef[0] = sp;
			if (r.poly_order == ORD_CUBIC) begin
				coef[1] = sv;
				if (t != 0) begin
					a = div_q(sat_mul(d, 3), t);
					a = sat_add(sat_add(a, sat_mul(sv, -2)), -ev);
					coef[2] = div_q(a, t);
					a = div_q(sat_mul(d, -2), t);
					a = sat_add(sat_add(a, sv), ev);
					coef[3] = div_q(div_q(a, t), t);
				end
			end else if (r.poly_order == ORD_QUINTIC) begin
				coef[1] = sv;
				coef[2] = sa / 2;
				if (t != 0) begin
					a = div_q(sat_mul(d, 20), t);
					a = sat_add(sat_add(a, sat_mul(sv, -12)), sat_mul(ev, -8));
					a = sat_add(sat_add(div_q(a, t), ea), sat_mul(sa, -3));
					coef[3] = div_q(a, t2);
					a = div_q(sat_mul(d, -30), t);
					a = sat_add(sat_add(a, sat_mul(sv, 16)), sat_mul(ev, 14));
					a = sat_add(sat_add(div_q(a, t), sat_mul(sa, 3)), sat_mul(ea, -2));
					coef[4] = div_q(div_q(a, t), t2);
					a = div_q(sat_mul(d, 12), t);
					a = sat_add(sat_add(a, sat_mul(sv, -6)), sat_mul(ev, -6));
					a = sat_add(sat_add(div_q(a, t), ea), -sa);
					coef[5] = div_q(div_q(div_q(a, t), t), t2);
				end
			end else if (t != 0) begin
				// Orders zero and one both load a straight line.
				coef[1] = div_q(d, t);
			end
			e.status = ST_LOADED;
		end else if (r.sample_time < seg_t0 || r.sample_time - seg_t0 > seg_len) begin
			e.status = ST_RANGE;
		end else begin
			x = r.sample_time - seg_t0;
			p = coef[5];
			for (int i = 4; i >= 0; i--)
				p = sat_add(mul_time(p, x), coef[i]);
			v = sat_mul(coef[5], 5);
			v = sat_add(mul_time(v, x), sat_mul(coef[4], 4));
			v = sat_add(mul_time(v, x), sat_mul(coef[3], 3));
			v = sat_add(mul_time(v, x), sat_mul(coef[2], 2));
			v = sat_add(mul_time(v, x), coef[1]);
			ac = sat_mul(coef[5], 20);
			ac = sat_add(mul_time(ac, x), sat_mul(coef[4], 12));
			ac = sat_add(mul_time(ac, x), sat_mul(coef[3], 6));
			ac = sat_add(mul_time(ac, x), sat_mul(coef[2], 2));
			e.status = ST_OK;
			e.out_pos = narrow(p);
			e.out_vel = narrow(v);
			e.out_acc = narrow(ac);
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		psi_rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				coef[i] = 0;
			seg_t0 = '0;
			seg_len = '0;
			expected_rsp.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: status %0d pos %h vel %h acc %h",
							rsp_data.status, rsp_data.out_pos, rsp_data.out_vel,
							rsp_data.out_acc);
				end else begin
					e = expected_rsp.pop_front();
					if (rsp_data.status !== e.status || rsp_data.out_pos !== e.out_pos ||
							rsp_data.out_vel !== e.out_vel || rsp_data.out_acc !== e.out_acc) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected st %0d %h %h %h, got st %0d %h %h %h",
								e.status, e.out_pos, e.out_vel, e.out_acc, rsp_data.status,
								rsp_data.out_pos, rsp_data.out_vel, rsp_data.out_acc);
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(interpolate(req_data));
			pending = expected_rsp.size();
		end
	end

endmodule

FILE: tb/sv/tb_polynomial_segment_interpolator_core.sv
// Testbench top for the polynomial segment interpolator: stimulus, idling and verdict.
module tb_polynomial_segment_interpolator_core;
	import psi_pkg::*;

	localparam logic [1:0] ORD_NONE = 2'd0;
	localparam logic [1:0] ORD_LINEAR = 2'd1;
	localparam int RANDOM_ITEMS = 2000;
	localparam int STALL_LIMIT = 40000;
	localparam logic [31:0] SEC = 32'h0001_0000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	psi_req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	psi_rsp_t rsp_data;
	int fail_count;
	int pending;

	int send_idle_pct;
	int recv_idle_pct;
	int loads_sent;
	int samples_sent;
	int quiet_cycles;

	polynomial_segment_interpolator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	psi_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a beat", STALL_LIMIT);
				$display("polynomial_segment_interpolator_core verification failed");
				$finish;
			end
		end
	end

	// Holds the beat until it is taken; called and returns at a falling edge.
	task automatic send_beat(input psi_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_data <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (r.req_type == REQ_LOAD)
			loads_sent++;
		else
			samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_load(input logic [1:0] ord, input logic [31:0] sp, input logic [31:0] sv,
			input logic [31:0] sa, input logic [31:0] ep, input logic [31:0] ev,
			input logic [31:0] ea, input logic [31:0] t0, input logic [31:0] dur);
		psi_req_t r;
		r.req_type = REQ_LOAD;
		r.poly_order = ord;
		r.start_pos = sp;
		r.start_vel = sv;
		r.start_acc = sa;
		r.end_pos = ep;
		r.end_vel = ev;
		r.end_acc = ea;
		r.seg_start_time = t0;
		r.seg_duration = dur;
		r.sample_time = $urandom;
		send_beat(r);
	endtask

	task automatic send_sample(input logic [31:0] stamp);
		psi_req_t r;
		r = $bits(psi_req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom});
		r.req_type = REQ_SAMPLE;
		r.sample_time = stamp;
		send_beat(r);
	endtask

	// Mostly modest values so the polynomials stay in range, with full-width and extreme ones.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_duration();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom;
			2: return $urandom_range(1, 255);
			default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
		endcase
	endfunction

	initial begin
		logic [31:0] t0;
		logic [31:0] dur;
		logic [31:0] span;
		int items;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_stall = 1'b0;
		send_idle_pct = 28;
		recv_idle_pct = 70;
		loads_sent = 0;
		samples_sent = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Before any load the cleared segment spans only stamp zero.
		send_sample(32'd0);
		send_sample(32'd1);
		send_load(ORD_LINEAR, -5 * SEC, 0, 0, 5 * SEC, 0, 0, SEC, 2 * SEC);
		send_sample(SEC);
		send_sample(SEC - 1);
		send_sample(2 * SEC);
		send_sample(3 * SEC);
		send_sample(3 * SEC + 1);
		send_load(ORD_CUBIC, SEC, 2 * SEC, 0, -3 * SEC, -SEC, 0, 0, 4 * SEC);
		send_sample(0);
		send_sample(SEC + 32'h8000);
		send_sample(4 * SEC);
		send_load(ORD_QUINTIC, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h100, 1);
		send_sample(32'h100);
		send_sample(32'h101);
		send_load(ORD_QUINTIC, 3 * SEC, SEC, -7 * SEC, 0, 0, 0, 32'h4000, 0);
		send_sample(32'h4000);
		send_sample(32'h4001);
		send_load(ORD_NONE, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0, 32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFF);
		send_load(ORD_CUBIC, SEC, SEC, SEC, 2 * SEC, SEC, SEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'hFFFF_FFFE);

		// Random segments, each followed by a run of samples mostly inside it.
		t0 = 0;
		dur = 0;
		for (items = 0; items < RANDOM_ITEMS; items++) begin
			if (items == RANDOM_ITEMS / 3) begin
				send_idle_pct = 70;
				recv_idle_pct = 28;
			end else if (items == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (items == 0 || $urandom_range(0, 9) == 0) begin
				t0 = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000);
				dur = pick_duration();
				send_load(2'($urandom_range(0, 3)), pick_value(), pick_value(), pick_value(),
					pick_value(), pick_value(), pick_value(), t0, dur);
			end else begin
				span = (dur > ~t0) ? ~t0 : dur;
				case ($urandom_range(0, 7))
					0: send_sample($urandom);
					1: send_sample(t0 - 1);
					2: send_sample(t0 + span + 1);
					default: send_sample(t0 + $urandom_range(0, span));
				endcase
			end
		end
		req_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
		$display("sent %0d segment loads and %0d samples over three idling phases",
			loads_sent, samples_sent);
		$display("orders zero to three, zero and full-width durations, stamps on and off each segment");
		if (fail_count == 0)
			$display("polynomial_segment_interpolator_core verification clean");
		else
			$display("polynomial_segment_interpolator_core verification failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/psi_pkg.sv
sv/psi_dpath.sv
sv/psi_ctrl.sv
sv/polynomial_segment_interpolator_core.sv
tb/sv/psi_checker.sv
tb/sv/tb_polynomial_segment_interpolator_core.sv
